// ===== src/calendar_date_next_and_difference_defines.svh =====
// Assertion macros for the calendar date block.
// Used by modules that hold clk_i and rst_ni; no other dependencies.
`ifndef CALENDAR_DATE_NEXT_AND_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_NEXT_AND_DIFFERENCE_DEFINES_SVH

// Property that holds in every cycle out of reset.
`define CDND_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CDND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cdnd_pkg.sv =====
// Shared types, constants and calendar tables for the date pipeline.
// No dependencies.
package cdnd_pkg;

  localparam int unsigned YearW     = 14;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned DayW      = 5;
  localparam int unsigned NextYearW = 15;
  localparam int unsigned DayNumW   = 23;
  localparam int unsigned DoyW      = 9;
  localparam int unsigned Q100W     = 8;

  localparam logic [YearW-1:0]  DefaultYear = 14'd1970;
  localparam logic [MonthW-1:0] MonthJan    = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb    = 4'd2;
  localparam logic [MonthW-1:0] MonthDec    = 4'd12;

  // Reciprocals scaled by 2^20; exact for all 14-bit operands.
  localparam int unsigned RecipShift = 20;
  localparam logic [16:0] Recip25    = 17'd41944;
  localparam logic [13:0] Recip100   = 14'd10486;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    date_t           date;
    logic            leap;
    logic [DayW-1:0] mlen;
  } vdate_t;

  typedef struct packed {
    logic [DayNumW-1:0] base;
    logic [YearW-3:0]   p_div4;
    logic [Q100W-1:0]   p_div100;
    logic [DoyW-1:0]    doy;
  } dnum_part_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MonthFeb:                len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before this one, common year.
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] month);
    logic [DoyW-1:0] n;
    case (month)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/cdnd_req_if.sv =====
// Input channel: two raw dates per beat, valid/ready handshake.
// Depends on cdnd_pkg for field widths.
interface cdnd_req_if;
  logic                          valid;
  logic                          ready;
  logic [cdnd_pkg::YearW-1:0]    year_a;
  logic [cdnd_pkg::MonthW-1:0]   month_a;
  logic [cdnd_pkg::DayW-1:0]     day_a;
  logic [cdnd_pkg::YearW-1:0]    year_b;
  logic [cdnd_pkg::MonthW-1:0]   month_b;
  logic [cdnd_pkg::DayW-1:0]     day_b;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  input ready);
  modport sink   (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  output ready);
endinterface

// ===== src/cdnd_rsp_if.sv =====
// Output channel: validated date, next day and day difference per beat.
// Depends on cdnd_pkg for field widths.
interface cdnd_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cdnd_pkg::YearW-1:0]     valid_year;
  logic [cdnd_pkg::MonthW-1:0]    valid_month;
  logic [cdnd_pkg::DayW-1:0]      valid_day;
  logic [cdnd_pkg::NextYearW-1:0] next_year;
  logic [cdnd_pkg::MonthW-1:0]    next_month;
  logic [cdnd_pkg::DayW-1:0]      next_day;
  logic [cdnd_pkg::DayNumW-1:0]   day_difference;

  modport source (output valid, valid_year, valid_month, valid_day, next_year,
                  next_month, next_day, day_difference, input ready);
  modport sink   (input valid, valid_year, valid_month, valid_day, next_year,
                  next_month, next_day, day_difference, output ready);
endinterface

// ===== src/cdnd_validate.sv =====
// Date repair: default year, bad month to January, leap test and day range check.
// Depends on cdnd_pkg.
module cdnd_validate (
  input  cdnd_pkg::date_t  raw_i,
  output cdnd_pkg::vdate_t vdate_o
);
  import cdnd_pkg::*;

  logic [YearW-1:0]  yy;
  logic [MonthW-1:0] mm;
  logic [DayW-1:0]   dd;
  logic [29:0]       prod25;
  logic [9:0]        q25;
  logic [YearW-1:0]  back25;
  logic              div25;
  logic              leap;
  logic [DayW-1:0]   mlen;

  always_comb begin
    yy = (raw_i.year == '0) ? DefaultYear : raw_i.year;
    mm = (raw_i.month == '0 || raw_i.month > MonthDec) ? MonthJan : raw_i.month;

    // y mod 25 == 0 via reciprocal multiply; times 25 back as shift-add
    prod25 = 30'(yy) * 30'(Recip25);
    q25    = prod25[RecipShift+9:RecipShift];
    back25 = 14'({q25, 4'b0}) + 14'({q25, 3'b0}) + 14'(q25);
    div25  = (back25 == yy);

    // div by 100 = div4 and div25; div by 400 = div16 and div25
    leap = (yy[1:0] == 2'b0) && (!div25 || yy[3:0] == 4'b0);
    mlen = month_len(mm, leap);
    dd   = (raw_i.day == '0 || raw_i.day > mlen) ? 5'd1 : raw_i.day;

    vdate_o.date.year  = yy;
    vdate_o.date.month = mm;
    vdate_o.date.day   = dd;
    vdate_o.leap       = leap;
    vdate_o.mlen       = mlen;
  end

endmodule

// ===== src/cdnd_daynum.sv =====
// Partial terms of the day number: 365*(y-1), (y-1)/4, (y-1)/100, day of year.
// Depends on cdnd_pkg.
module cdnd_daynum (
  input  cdnd_pkg::vdate_t     vdate_i,
  output cdnd_pkg::dnum_part_t part_o
);
  import cdnd_pkg::*;

  logic [YearW-1:0] p;
  logic [27:0]      prod100;
  logic             past_feb;

  always_comb begin
    p        = vdate_i.date.year - 14'd1;
    prod100  = 28'(p) * 28'(Recip100);
    past_feb = (vdate_i.date.month > MonthFeb) && vdate_i.leap;

    part_o.base     = 23'(p) * 23'd365;
    part_o.p_div4   = p[YearW-1:2];
    part_o.p_div100 = prod100[RecipShift+Q100W-1:RecipShift];
    part_o.doy      = days_before(vdate_i.date.month) + 9'(past_feb)
                    + 9'(vdate_i.date.day);
  end

endmodule

// ===== src/calendar_date_next_and_difference.sv =====
// Channel  Dir  Content
// req_i    in   raw dates a and b (year, month, day each)
// rsp_o    out  validated a, the day after a, |daynum(b) - daynum(a)|
//
// Four register stages: repair, next day and day-number terms, day-number
// sum, absolute difference into the output register. One beat enters per
// cycle while the output is not held. Each stage takes a new beat when it is
// empty or moving on, so bubbles are absorbed while the output is held. Reset
// clears the stage valid bits only.
// Depends on cdnd_pkg, cdnd_req_if, cdnd_rsp_if, cdnd_validate, cdnd_daynum.
`include "calendar_date_next_and_difference_defines.svh"

module calendar_date_next_and_difference (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdnd_req_if.sink          req_i,
  cdnd_rsp_if.source        rsp_o
);
  import cdnd_pkg::*;

  date_t      raw_a, raw_b;
  vdate_t     va_d, vb_d;
  dnum_part_t pa_d, pb_d;

  logic       s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic       rdy1, rdy2, rdy3, rdy4;

  vdate_t     s1_va_q, s1_vb_q;

  date_t                s2_a_q, s3_a_q, s4_a_q;
  logic [NextYearW-1:0] nxt_year_d, s2_nyear_q, s3_nyear_q, s4_nyear_q;
  logic [MonthW-1:0]    nxt_month_d, s2_nmonth_q, s3_nmonth_q, s4_nmonth_q;
  logic [DayW-1:0]      nxt_day_d, s2_nday_q, s3_nday_q, s4_nday_q;
  dnum_part_t           s2_pa_q, s2_pb_q;

  logic [DayNumW-1:0]   na_d, nb_d, s3_na_q, s3_nb_q;
  logic [DayNumW-1:0]   diff_d, s4_diff_q;

  assign rdy4        = !s4_vld_q || rsp_o.ready;
  assign rdy3        = !s3_vld_q || rdy4;
  assign rdy2        = !s2_vld_q || rdy3;
  assign rdy1        = !s1_vld_q || rdy2;
  assign req_i.ready = rdy1;

  assign raw_a = '{year: req_i.year_a, month: req_i.month_a, day: req_i.day_a};
  assign raw_b = '{year: req_i.year_b, month: req_i.month_b, day: req_i.day_b};

  cdnd_validate u_val_a (.raw_i(raw_a), .vdate_o(va_d));
  cdnd_validate u_val_b (.raw_i(raw_b), .vdate_o(vb_d));

  cdnd_daynum u_dn_a (.vdate_i(s1_va_q), .part_o(pa_d));
  cdnd_daynum u_dn_b (.vdate_i(s1_vb_q), .part_o(pb_d));

  // Day after a
  always_comb begin
    nxt_year_d  = 15'(s1_va_q.date.year);
    nxt_month_d = s1_va_q.date.month;
    nxt_day_d   = s1_va_q.date.day + 5'd1;
    if (s1_va_q.date.day == s1_va_q.mlen) begin
      nxt_day_d = 5'd1;
      if (s1_va_q.date.month == MonthDec) begin
        nxt_month_d = MonthJan;
        nxt_year_d  = 15'(s1_va_q.date.year) + 15'd1;
      end else begin
        nxt_month_d = s1_va_q.date.month + 4'd1;
      end
    end
  end

  always_comb begin
    na_d = s2_pa_q.base + 23'(s2_pa_q.p_div4) - 23'(s2_pa_q.p_div100)
         + 23'(s2_pa_q.p_div100[Q100W-1:2]) + 23'(s2_pa_q.doy);
    nb_d = s2_pb_q.base + 23'(s2_pb_q.p_div4) - 23'(s2_pb_q.p_div100)
         + 23'(s2_pb_q.p_div100[Q100W-1:2]) + 23'(s2_pb_q.doy);
    diff_d = (s3_na_q > s3_nb_q) ? (s3_na_q - s3_nb_q) : (s3_nb_q - s3_na_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (rdy1) s1_vld_q <= req_i.valid;
      if (rdy2) s2_vld_q <= s1_vld_q;
      if (rdy3) s3_vld_q <= s2_vld_q;
      if (rdy4) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) begin
      s1_va_q <= va_d;
      s1_vb_q <= vb_d;
    end
    if (rdy2 && s1_vld_q) begin
      s2_a_q      <= s1_va_q.date;
      s2_nyear_q  <= nxt_year_d;
      s2_nmonth_q <= nxt_month_d;
      s2_nday_q   <= nxt_day_d;
      s2_pa_q     <= pa_d;
      s2_pb_q     <= pb_d;
    end
    if (rdy3 && s2_vld_q) begin
      s3_a_q      <= s2_a_q;
      s3_nyear_q  <= s2_nyear_q;
      s3_nmonth_q <= s2_nmonth_q;
      s3_nday_q   <= s2_nday_q;
      s3_na_q     <= na_d;
      s3_nb_q     <= nb_d;
    end
    if (rdy4 && s3_vld_q) begin
      s4_a_q      <= s3_a_q;
      s4_nyear_q  <= s3_nyear_q;
      s4_nmonth_q <= s3_nmonth_q;
      s4_nday_q   <= s3_nday_q;
      s4_diff_q   <= diff_d;
    end
  end

  assign rsp_o.valid          = s4_vld_q;
  assign rsp_o.valid_year     = s4_a_q.year;
  assign rsp_o.valid_month    = s4_a_q.month;
  assign rsp_o.valid_day      = s4_a_q.day;
  assign rsp_o.next_year      = s4_nyear_q;
  assign rsp_o.next_month     = s4_nmonth_q;
  assign rsp_o.next_day       = s4_nday_q;
  assign rsp_o.day_difference = s4_diff_q;

  `CDND_ASSERT(a_month_range, !s4_vld_q || (s4_a_q.month >= MonthJan && s4_a_q.month <= MonthDec && s4_a_q.day != '0), "validated date out of range")
  `CDND_ASSERT(a_month_roll, !s4_vld_q || s4_nmonth_q == s4_a_q.month || s4_nday_q == 5'd1, "month changed without day reset")
  `CDND_ASSERT(a_year_roll, !s4_vld_q || s4_nyear_q == 15'(s4_a_q.year) || (s4_nmonth_q == MonthJan && s4_a_q.month == MonthDec), "year changed outside December")
  `CDND_ASSERT_NEXT(a_s3_hold, s3_vld_q && !rdy4, s3_vld_q, "stalled beat dropped in stage 3")

endmodule

// ===== test/cdnd_date_checker.sv =====
// Scoreboard for the calendar date block: predicts every request beat and
// checks the response beats in order. Depends on cdnd_pkg, cdnd_req_if and cdnd_rsp_if.
module cdnd_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdnd_req_if         req_i,
  cdnd_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    int unsigned year;
    int unsigned month;
    int unsigned day;
  } cal_date_t;

  typedef struct packed {
    logic [cdnd_pkg::YearW-1:0]     year;
    logic [cdnd_pkg::MonthW-1:0]    month;
    logic [cdnd_pkg::DayW-1:0]      day;
    logic [cdnd_pkg::NextYearW-1:0] next_year;
    logic [cdnd_pkg::MonthW-1:0]    next_month;
    logic [cdnd_pkg::DayW-1:0]      next_day;
    logic [cdnd_pkg::DayNumW-1:0]   span;
  } date_result_t;

  date_result_t expected_dates[$];

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = is_leap(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic cal_date_t repair_date(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
    cal_date_t c;
    c.year  = (y == 0) ? int'(cdnd_pkg::DefaultYear) : y;
    c.month = (m < 1 || m > 12) ? 1 : m;
    c.day   = (d < 1 || d > month_length(c.year, c.month)) ? 1 : d;
    return c;
  endfunction

  // Days in all full years before the date plus its day of the year.
  function automatic int unsigned day_index(input cal_date_t c);
    int unsigned p;
    int unsigned n;
    p = c.year - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    // year 1 is a common year, so this sums the common month lengths
    for (int unsigned i = 1; i < c.month; i++) n += month_length(1, i);
    if (c.month > 2 && is_leap(c.year)) n += 1;
    return n + c.day;
  endfunction

  function automatic date_result_t predict_dates(input int unsigned ya, input int unsigned ma,
                                                 input int unsigned da, input int unsigned yb,
                                                 input int unsigned mb, input int unsigned db);
    cal_date_t    a;
    cal_date_t    b;
    int unsigned  na;
    int unsigned  nb;
    date_result_t r;
    a = repair_date(ya, ma, da);
    b = repair_date(yb, mb, db);
    r.year  = 14'(a.year);
    r.month = 4'(a.month);
    r.day   = 5'(a.day);
    if (a.day == month_length(a.year, a.month)) begin
      r.next_day = 5'd1;
      if (a.month == 12) begin
        r.next_month = 4'd1;
        r.next_year  = 15'(a.year + 1);
      end else begin
        r.next_month = 4'(a.month + 1);
        r.next_year  = 15'(a.year);
      end
    end else begin
      r.next_day   = 5'(a.day + 1);
      r.next_month = 4'(a.month);
      r.next_year  = 15'(a.year);
    end
    na = day_index(a);
    nb = day_index(b);
    r.span = 23'((na > nb) ? na - nb : nb - na);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        expected_dates.push_back(predict_dates(32'(req_i.year_a), 32'(req_i.month_a),
                                               32'(req_i.day_a), 32'(req_i.year_b),
                                               32'(req_i.month_b), 32'(req_i.day_b)));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %0d-%0d-%0d diff %0d", $time,
                   rsp_i.valid_year, rsp_i.valid_month, rsp_i.valid_day,
                   rsp_i.day_difference);
          fail_count_o++;
        end else begin
          want = expected_dates.pop_front();
          compare_field("valid_year", 32'(want.year), 32'(rsp_i.valid_year));
          compare_field("valid_month", 32'(want.month), 32'(rsp_i.valid_month));
          compare_field("valid_day", 32'(want.day), 32'(rsp_i.valid_day));
          compare_field("next_year", 32'(want.next_year), 32'(rsp_i.next_year));
          compare_field("next_month", 32'(want.next_month), 32'(rsp_i.next_month));
          compare_field("next_day", 32'(want.next_day), 32'(rsp_i.next_day));
          compare_field("day_difference", 32'(want.span), 32'(rsp_i.day_difference));
        end
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the calendar date bench: clock, reset, date-pair stimulus, output
// back-pressure and the verdict. Depends on the block, its interfaces and cdnd_date_checker.
module testbench;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;

  cdnd_req_if req ();
  cdnd_rsp_if rsp ();

  calendar_date_next_and_difference u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  cdnd_date_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned rand_year();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return $urandom_range(0, 16383);
      4, 5:       return $urandom_range(1900, 2100);
      6:          return 100 * $urandom_range(0, 163);
      7:          return 400 * $urandom_range(0, 40);
      8: begin
        case ($urandom_range(0, 3))
          0:       return 0;
          1:       return 1;
          2:       return 16382;
          default: return 16383;
        endcase
      end
      default:    return 4 * $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int unsigned rand_month();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return $urandom_range(0, 15);
    if (r == 1) return 2;
    return $urandom_range(1, 12);
  endfunction

  // Lean on month ends, where the repair and the carry live.
  function automatic int unsigned rand_day();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(27, 31);
    if (r < 8) return $urandom_range(0, 31);
    return $urandom_range(1, 26);
  endfunction

  task automatic offer_pair(input int unsigned ya, input int unsigned ma, input int unsigned da,
                            input int unsigned yb, input int unsigned mb, input int unsigned db,
                            input int unsigned gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.year_a  <= 14'(ya);
    req.month_a <= 4'(ma);
    req.day_a   <= 5'(da);
    req.year_b  <= 14'(yb);
    req.month_b <= 4'(mb);
    req.day_b   <= 5'(db);
    do @(posedge clk_i); while (!req.ready);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted beat has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Output side: random back-pressure, one long hold-off once the bench is busy.
  initial begin
    int unsigned r;
    int unsigned n;
    bit          held_long;
    held_long = 1'b0;
    rsp.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held_long && items_sent >= 300) begin
        held_long = 1'b1;
        rsp.ready <= 1'b0;
        n = 200;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          rsp.ready <= 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 55) begin
          rsp.ready <= 1'b1;
          n = 100;
        end else if (r < 88) begin
          rsp.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else if (r < 97) begin
          rsp.ready <= 1'b0;
          n = $urandom_range(4, 12);
        end else begin
          rsp.ready <= 1'b0;
          n = $urandom_range(20, 50);
        end
      end
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned ya;
    int unsigned ma;
    int unsigned da;
    int unsigned yb;
    int unsigned mb;
    int unsigned db;
    int unsigned gap;
    rst_ni      = 1'b0;
    items_sent  = 0;
    req.valid   = 1'b0;
    req.year_a  = '0;
    req.month_a = '0;
    req.day_a   = '0;
    req.year_b  = '0;
    req.month_b = '0;
    req.day_b   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero dates fall back to 1 January 1970
    offer_pair(0, 0, 0, 0, 0, 0, pick_gap());
    // widest span, and the year carry past the top of the year field
    offer_pair(16383, 12, 31, 1, 1, 1, pick_gap());
    offer_pair(1, 1, 1, 16383, 12, 31, pick_gap());
    // leap February: century divisible by 400, ordinary leap year
    offer_pair(2000, 2, 28, 2000, 3, 1, pick_gap());
    offer_pair(2000, 2, 29, 1999, 12, 31, pick_gap());
    offer_pair(2024, 2, 28, 2024, 12, 31, pick_gap());
    offer_pair(16000, 2, 29, 15999, 2, 28, pick_gap());
    // 29 February in common years repairs to day 1
    offer_pair(1900, 2, 29, 1900, 2, 28, pick_gap());
    offer_pair(2023, 2, 29, 2023, 3, 1, pick_gap());
    offer_pair(2100, 2, 28, 2400, 2, 29, pick_gap());
    offer_pair(16383, 2, 28, 4, 2, 29, pick_gap());
    offer_pair(10000, 11, 30, 0, 2, 29, pick_gap());
    // same year: a after b, and equal dates
    offer_pair(2024, 12, 31, 2024, 1, 1, pick_gap());
    offer_pair(2023, 6, 30, 2023, 6, 30, pick_gap());
    // day past the month end, day zero, bad months
    offer_pair(1999, 4, 31, 1999, 4, 30, pick_gap());
    offer_pair(8191, 10, 31, 16383, 9, 31, pick_gap());
    offer_pair(1999, 13, 15, 1999, 15, 31, pick_gap());
    offer_pair(1999, 0, 31, 0, 12, 31, pick_gap());
    offer_pair(5, 6, 0, 5, 6, 30, pick_gap());
    offer_pair(16383, 15, 31, 16383, 0, 0, pick_gap());
    offer_pair(1, 12, 31, 2, 1, 1, pick_gap());
    offer_pair(2020, 1, 31, 2019, 11, 30, pick_gap());
    wait_drained();

    for (int unsigned i = 0; i < 730; i++) begin
      if (i == 400) wait_drained();
      ya = rand_year();
      ma = rand_month();
      da = rand_day();
      case ($urandom_range(0, 9))
        0: begin
          yb = ya;
          mb = ma;
          db = da;
        end
        1, 2: begin
          yb = ya;
          mb = rand_month();
          db = rand_day();
        end
        default: begin
          yb = rand_year();
          mb = rand_month();
          db = rand_day();
        end
      endcase
      // every 200 beats, run a stretch back to back
      gap = (i % 200 < 40) ? 0 : pick_gap();
      offer_pair(ya, ma, da, yb, mb, db, gap);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== calendar_date_next_and_difference.f =====
+incdir+src
src/cdnd_pkg.sv
src/cdnd_req_if.sv
src/cdnd_rsp_if.sv
src/cdnd_validate.sv
src/cdnd_daynum.sv
src/calendar_date_next_and_difference.sv
test/cdnd_date_checker.sv
test/testbench.sv
